// ===== rtl/dpcc_pkg.sv =====
// dosing pump cycle controller package: phase, command and state encodings,
// controller/datapath command and status structs; no dependencies
package dpcc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_START   = 2'd1,
    PH_PUMP    = 2'd2,
    PH_LOCKOUT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_SETUP   = 3'd1,
    CMD_RUN     = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_WORK    = 3'd4,
    CMD_RELEASE = 3'd5
  } motor_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TOTAL,
    ST_DIV_SHARE,
    ST_STEP,
    ST_OUT
  } ctrl_state_e;

  localparam logic [2:0] REG_CAL   = 3'd0;
  localparam logic [2:0] REG_CYC   = 3'd1;
  localparam logic [2:0] REG_DOSE  = 3'd2;
  localparam logic [2:0] REG_FB    = 3'd3;
  localparam logic [2:0] REG_DEBUG = 3'd4;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivSteps = 32;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch input transaction, start update divide
    logic div_start;  // start target / duration divide
    logic step;       // apply the phase step
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
  } dp_status_t;

endpackage

// ===== rtl/dpcc_if.sv =====
// valid/ready channel interface carrying a generic payload
// depends on nothing
interface dpcc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/dpcc_divider.sv =====
// shared radix-2 restoring divider, 32-bit dividend by 16-bit divisor
// depends on dpcc_pkg
module dpcc_divider
  import dpcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  logic [31:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [16:0] trial;
  logic [17:0] sub;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[15:0], quot_q[31]};
    sub    = {1'b0, trial} - {2'b0, div_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 6'(DivSteps);
    end else if (cnt_q != '0) begin
      if (!sub[17]) begin
        rem_d = sub[16:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

// ===== rtl/dpcc_ctrl.sv =====
// controller state machine sequencing accept, divides, phase step and output
// depends on dpcc_pkg
module dpcc_ctrl
  import dpcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);
  ctrl_state_e state_q, state_d;
  logic        kick_q, kick_d;

  always_comb begin
    state_d = state_q;
    kick_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV_TOTAL;
          kick_d  = 1'b1;
        end
      end
      ST_DIV_TOTAL: begin
        if (!kick_q && !status_i.div_busy) begin
          state_d = ST_DIV_SHARE;
          kick_d  = 1'b1;
        end
      end
      ST_DIV_SHARE: begin
        if (!kick_q && !status_i.div_busy) state_d = ST_STEP;
      end
      ST_STEP: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_ready_o      = (state_q == ST_IDLE);
    out_valid_o     = (state_q == ST_OUT);
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == ST_DIV_TOTAL) && !kick_q && !status_i.div_busy;
    cmd_o.step      = (state_q == ST_STEP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kick_q  <= kick_d;
    end
  end

`ifndef SYNTHESIS
  a_out_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> out_valid_o) else $error("step not followed by output");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_step_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !status_i.div_busy) else $error("step during divide");
`endif
endmodule

// ===== rtl/dpcc_datapath.sv =====
// datapath: latched config, phase registers, multiplier, shared divider use
// depends on dpcc_pkg, dpcc_divider
module dpcc_datapath
  import dpcc_pkg::*;
#(
  parameter int unsigned CYCLE_PERIOD_MS = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic [15:0] cfg_cal_i,
  input  logic [15:0] cfg_cyc_i,
  input  logic [15:0] cfg_dose_i,
  input  logic        cfg_fb_i,
  input  logic        cfg_debug_i,
  input  logic        enable_i,
  input  logic [31:0] feedback_count_i,
  input  logic [31:0] now_ms_i,
  input  logic        update_strobe_i,
  input  logic        driver_present_i,
  input  logic        driver_default_i,
  output logic [1:0]  phase_o,
  output logic        busy_flag_o,
  output logic        error_flag_o,
  output logic [2:0]  motor_command_o,
  output logic [15:0] total_dispensed_o,
  output logic [15:0] cycles_left_o,
  output logic [15:0] dose_per_cycle_o,
  output logic        feedback_clear_o,
  output logic        feedback_channel_on_o
);
  // latched input transaction
  logic        en_q, strobe_q, present_q, dflt_q;
  logic [31:0] fb_q, now_q;
  logic [15:0] cal_cfg_q, cyc_cfg_q;
  logic        fbm_q, dbgm_q;
  logic [31:0] prod_q;
  logic [31:0] upd_quot_q;

  phase_e      phase_q, phase_d;
  logic        debug_q, debug_d, fbl_q, fbl_d, dfl_q, dfl_d, held_q, held_d;
  logic [15:0] cal_q, cal_d, dur_q, dur_d, dose_q, dose_d, cyc_q, cyc_d;
  logic [31:0] target_q, target_d, cend_q, cend_d, dl_q, dl_d;
  logic [15:0] total_q, total_d;
  logic        busy_q, busy_d, err_q, err_d;
  motor_cmd_e  mcmd_q, mcmd_d;
  logic        clr_q, clr_d;

  logic        div_start, div_busy;
  logic [31:0] div_a, div_quot;
  logic [15:0] div_b, cal_new, dur_new;
  logic [31:0] per;

  assign cal_new = (cfg_cal_i != '0) ? cfg_cal_i : 16'd1;
  assign dur_new = (cyc_cfg_q != '0) ? cyc_cfg_q : 16'd1;

  // first divide: update report, fb / cal_latched; second: target / duration
  assign div_start = cmd_i.accept || cmd_i.div_start;
  assign div_a     = cmd_i.accept ? feedback_count_i : prod_q;
  assign div_b     = cmd_i.accept ? cal_q : dur_new;

  dpcc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign status_o.div_busy = div_busy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      en_q       <= enable_i;
      strobe_q   <= update_strobe_i;
      present_q  <= driver_present_i;
      dflt_q     <= driver_default_i;
      fb_q       <= feedback_count_i;
      now_q      <= now_ms_i;
      cal_cfg_q  <= cal_new;
      cyc_cfg_q  <= cfg_cyc_i;
      fbm_q      <= cfg_fb_i;
      dbgm_q     <= cfg_debug_i;
      prod_q     <= cal_new * cfg_dose_i;
    end
    if (cmd_i.div_start) upd_quot_q <= div_quot;
  end

  assign per = (div_quot == '0) ? 32'd1 : div_quot;

  always_comb begin
    phase_d  = phase_q;   debug_d = debug_q; fbl_d = fbl_q; dfl_d = dfl_q;
    held_d   = held_q;    cal_d = cal_q;     dur_d = dur_q;
    dose_d   = dose_q;    cyc_d = cyc_q;     target_d = target_q;
    cend_d   = cend_q;    dl_d = dl_q;       total_d = total_q;
    busy_d   = busy_q;    err_d = err_q;
    mcmd_d   = mcmd_q;    clr_d = clr_q;
    if (cmd_i.step) begin
      mcmd_d = CMD_NONE;
      clr_d  = 1'b0;
      if (strobe_q && cal_q != '0) total_d = upd_quot_q[15:0];
      case (phase_q)
        PH_IDLE: begin
          if (en_q) begin
            if (!present_q) begin
              held_d = 1'b0; phase_d = PH_LOCKOUT; err_d = 1'b1;
            end else begin
              held_d = 1'b1;
              dfl_d  = dflt_q;
              if (!dflt_q) begin
                mcmd_d = CMD_SETUP; phase_d = PH_LOCKOUT;
              end else begin
                // product of two 16-bit values never reaches the overflow limit
                fbl_d    = fbm_q;
                debug_d  = dbgm_q;
                cal_d    = cal_cfg_q;
                dur_d    = dur_new;
                clr_d    = 1'b1;
                target_d = prod_q;
                cyc_d    = dur_new;
                dose_d   = per[15:0];
                dl_d     = now_q;
                total_d  = '0;
                busy_d   = 1'b1;
                err_d    = 1'b0;
                mcmd_d   = CMD_SETUP;
                phase_d  = PH_START;
              end
            end
          end
        end
        PH_START: begin
          if (now_q > dl_q) begin
            if (!en_q || (target_q <= fb_q && !debug_q)) begin
              phase_d = PH_LOCKOUT; busy_d = 1'b0;
            end else begin
              cend_d  = 32'(dur_q - cyc_q) * 32'(dose_q);
              dl_d    = dl_q + 32'(CYCLE_PERIOD_MS);
              if (cyc_q != '0) cyc_d = cyc_q - 16'd1;
              mcmd_d  = CMD_RUN;
              phase_d = PH_PUMP;
            end
          end
        end
        PH_PUMP: begin
          if (target_q <= fb_q || cend_q <= fb_q || !en_q) begin
            if (!(debug_q && en_q)) begin
              mcmd_d = CMD_STOP; phase_d = PH_START;
            end
          end else begin
            mcmd_d = CMD_WORK;
          end
        end
        default: begin
          if (!en_q) begin
            err_d = 1'b0; phase_d = PH_IDLE;
            if (held_q) begin
              mcmd_d = CMD_RELEASE; held_d = 1'b0;
            end
          end else if (held_q && !dfl_q) begin
            mcmd_d = CMD_WORK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; debug_q <= 1'b0; fbl_q <= 1'b0; dfl_q <= 1'b0;
      held_q <= 1'b0; cal_q <= '0; dur_q <= '0; dose_q <= '0; cyc_q <= '0;
      target_q <= '0; cend_q <= '0; dl_q <= '0; total_q <= '0;
      busy_q <= 1'b0; err_q <= 1'b0; mcmd_q <= CMD_NONE; clr_q <= 1'b0;
    end else begin
      phase_q <= phase_d; debug_q <= debug_d; fbl_q <= fbl_d; dfl_q <= dfl_d;
      held_q <= held_d; cal_q <= cal_d; dur_q <= dur_d; dose_q <= dose_d;
      cyc_q <= cyc_d; target_q <= target_d; cend_q <= cend_d; dl_q <= dl_d;
      total_q <= total_d; busy_q <= busy_d; err_q <= err_d;
      mcmd_q <= mcmd_d; clr_q <= clr_d;
    end
  end

  assign phase_o               = phase_q;
  assign busy_flag_o           = busy_q;
  assign error_flag_o          = err_q;
  assign motor_command_o       = mcmd_q;
  assign total_dispensed_o     = total_q;
  assign cycles_left_o         = cyc_q;
  assign dose_per_cycle_o      = dose_q;
  assign feedback_clear_o      = clr_q;
  assign feedback_channel_on_o = fbl_q;

`ifndef SYNTHESIS
  a_release_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mcmd_q == CMD_RELEASE) |-> (phase_q == PH_IDLE && !held_q))
    else $error("release without idle");
  a_clear_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (mcmd_q == CMD_SETUP)) else $error("clear without setup");
  a_run_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mcmd_q == CMD_RUN) |-> (phase_q == PH_PUMP)) else $error("run outside pumping");
`endif
endmodule

// ===== rtl/dosing_pump_cycle_controller.sv =====
// dosing pump cycle controller top level: channels, config registers,
// controller and datapath; depends on dpcc_pkg, dpcc_if, dpcc_ctrl, dpcc_datapath
//
// each input transaction is one tick and yields exactly one result transaction.
// the result goes valid after the feedback / calibration divide started by the
// accept, the launch of the second divide, the target / cycle count divide
// giving the per-cycle share, the exit from the divide wait and the phase step.
// the result is then held until taken; the next tick is accepted only once the
// result has been taken and the controller is back in idle, so a new tick is
// never taken while the last one is in flight. both divides run on one shared
// bit-serial divider. configuration registers take effect at the next accepted
// tick; they are to be written only while idle, which the user must ensure:
// the block itself does not enforce it.
module dosing_pump_cycle_controller
  import dpcc_pkg::*;
#(
  parameter int unsigned CYCLE_PERIOD_MS = 1000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dpcc_if.sink                in_if,
  dpcc_if.source              out_if
);
  logic [15:0] cal_q, cyc_q, dose_q;
  logic        fbm_q, dbg_q;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0; cyc_q <= '0; dose_q <= '0; fbm_q <= 1'b0; dbg_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CAL:   cal_q  <= cfg_data_i;
        REG_CYC:   cyc_q  <= cfg_data_i;
        REG_DOSE:  dose_q <= cfg_data_i;
        REG_FB:    fbm_q  <= cfg_data_i[0];
        REG_DEBUG: dbg_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  dpcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath holds all tick state and the registered result
  dpcc_datapath #(.CYCLE_PERIOD_MS(CYCLE_PERIOD_MS)) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_cal_i             (cal_q),
    .cfg_cyc_i             (cyc_q),
    .cfg_dose_i            (dose_q),
    .cfg_fb_i              (fbm_q),
    .cfg_debug_i           (dbg_q),
    .enable_i              (in_if.payload.enable),
    .feedback_count_i      (in_if.payload.feedback_count),
    .now_ms_i              (in_if.payload.now_ms),
    .update_strobe_i       (in_if.payload.update_strobe),
    .driver_present_i      (in_if.payload.driver_present),
    .driver_default_i      (in_if.payload.driver_default),
    .phase_o               (out_if.payload.phase),
    .busy_flag_o           (out_if.payload.busy_flag),
    .error_flag_o          (out_if.payload.error_flag),
    .motor_command_o       (out_if.payload.motor_command),
    .total_dispensed_o     (out_if.payload.total_dispensed),
    .cycles_left_o         (out_if.payload.cycles_left),
    .dose_per_cycle_o      (out_if.payload.dose_per_cycle),
    .feedback_clear_o      (out_if.payload.feedback_clear),
    .feedback_channel_on_o (out_if.payload.feedback_channel_on)
  );
endmodule
